// ===== sv/orstep_pkg.sv =====
// Shared types and constants for the oligomer recombination step block.
package orstep_pkg;
  localparam int unsigned LEN_W   = 10;
  localparam int unsigned CNT_W   = 27;
  localparam int unsigned PROB_W  = 17;
  localparam int unsigned RAND_W  = 32;
  localparam int unsigned DRAW_W  = 16;
  localparam int unsigned CFG_W   = 17;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned GRADED_BELOW = 5;
  localparam int unsigned LONG_PIECE   = 100;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_EVENT = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_LOADED    = 3'd0,
    ST_READ      = 3'd1,
    ST_BROKEN    = 3'd2,
    ST_MONOMER   = 3'd3,
    ST_RECOMB    = 3'd4,
    ST_REJECTED  = 3'd5,
    ST_EXHAUSTED = 3'd6
  } status_t;

  typedef enum logic [CIDX_W-1:0] {
    CFG_SEL_MIN  = 3'd0,
    CFG_REC_MIN  = 3'd1,
    CFG_HYD_TH   = 3'd2,
    CFG_GRADED   = 3'd3,
    CFG_PROB1    = 3'd4,
    CFG_PROB2    = 3'd5,
    CFG_PROB3    = 3'd6,
    CFG_PROB4    = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [LEN_W-1:0]  length_a;
    logic [LEN_W-1:0]  length_b;
    logic [CNT_W-1:0]  count_out;
    logic [LEN_W-1:0]  max_length;
    logic [31:0]       long_product_count;
    logic [31:0]       event_count;
  } res_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [LEN_W-1:0]  bin_length;
    logic [CNT_W-1:0]  bin_count;
    logic [RAND_W-1:0] rand_first;
    logic [RAND_W-1:0] rand_second;
    logic [DRAW_W-1:0] rand_choice;
    logic [RAND_W-1:0] rand_cut;
    logic [DRAW_W-1:0] rand_grade;
  } item_t;
endpackage

// ===== sv/orstep_if.sv =====
// Valid/ready channel interface carrying one payload.
interface orstep_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/oligomer_recombination_step_top.sv =====
// Top level of the oligomer recombination step block.
// One item is handled at a time. After reset a clearing pass zeroes the
// 1024-entry histogram memory, one entry per cycle, and until it ends no
// item is taken (configuration writes still are). An event walks the
// memory through its single read port: one pass sums the eligible counts,
// two passes find the two picks, and a shared 32x32 multiplier scales the
// draws and the cut; a pick pass stops at the chosen bin. The block is
// ready only between items and only while no result beat is waiting; the
// result beat is held in an output register until the sink takes it.
module oligomer_recombination_step_top (
  input  logic clk,
  input  logic rst_n,
  orstep_if.sink   in_ch,
  orstep_if.source out_ch,
  input  logic                       cfg_we,
  input  logic [orstep_pkg::CIDX_W-1:0] cfg_idx,
  input  logic [orstep_pkg::CFG_W-1:0]  cfg_data
);
  import orstep_pkg::*;

  localparam int unsigned LEN_BITS   = LEN_W;
  localparam int unsigned COUNT_BITS = CNT_W;
  localparam int unsigned DEPTH = 1 << LEN_BITS;
  localparam int unsigned TOT_W = COUNT_BITS + LEN_BITS;
  localparam logic [COUNT_BITS-1:0] CMAX = '1;
  localparam logic [LEN_BITS-1:0]   LAST = '1;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_RD, S_RDW, S_LD, S_SUM_A, S_SUM_W, S_CHK,
    S_MUL, S_MULW, S_PICK_A, S_PICK_W, S_DEC, S_CHOOSE, S_CUT, S_CUTW,
    S_DECIDE, S_ADD_A, S_ADD_W, S_ADD_WR, S_OUT
  } state_t;

  state_t state_r;
  logic [COUNT_BITS-1:0] mem [DEPTH];
  logic [COUNT_BITS-1:0] rdata_r;
  logic [LEN_BITS-1:0]   addr_r;
  logic                  we;
  logic [LEN_BITS-1:0]   waddr;
  logic [COUNT_BITS-1:0] wdata;

  logic [LEN_BITS-1:0] sel_min_r, rec_min_r;
  logic [PROB_W-1:0]   hyd_r;
  logic                graded_r;
  logic [PROB_W-1:0]   prob_r [4];

  item_t item_r;
  res_t  res_r;
  logic  out_valid_r;
  logic [LEN_BITS-1:0] largest_r;
  logic [31:0] long_r, events_r;
  logic [TOT_W-1:0] total_r, run_r, idx_r;
  logic [LEN_BITS-1:0] pick_a_r, pick_b_r, scan_r;
  logic second_r;
  logic [63:0] prod_r;
  logic [31:0] mul_a, mul_b;
  logic [1:0]  mul_step_r;
  logic [TOT_W-1:0] mul_n_r;
  logic [TOT_W-1:0] acc_r;
  logic [LEN_BITS:0] cut_r, other_r;
  logic [1:0] adds_r;
  logic [LEN_BITS:0] add_len [3];
  logic [1:0] nadd_r;
  logic [LEN_BITS-1:0] first_elig;
  logic [LEN_BITS-1:0] rmin, mlen;

  assign first_elig = (sel_min_r == '0) ? LEN_BITS'(1) : sel_min_r;
  assign rmin = (rec_min_r == '0) ? LEN_BITS'(1) : rec_min_r;
  assign mlen = (pick_a_r < pick_b_r) ? pick_a_r : pick_b_r;

  // Memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[addr_r];
  end

  always_ff @(posedge clk) begin
    prod_r <= 64'(mul_a) * 64'(mul_b);
  end

  assign in_ch.ready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_min_r <= LEN_BITS'(1);
      rec_min_r <= LEN_BITS'(1);
      hyd_r <= '0;
      graded_r <= 1'b0;
      prob_r[0] <= PROB_W'(13107);
      prob_r[1] <= PROB_W'(26214);
      prob_r[2] <= PROB_W'(39322);
      prob_r[3] <= PROB_W'(52429);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_SEL_MIN: sel_min_r <= LEN_BITS'(cfg_data[9:0]);
        CFG_REC_MIN: rec_min_r <= LEN_BITS'(cfg_data[9:0]);
        CFG_HYD_TH:  hyd_r <= cfg_data;
        CFG_GRADED:  graded_r <= cfg_data[0];
        CFG_PROB1:   prob_r[0] <= cfg_data;
        CFG_PROB2:   prob_r[1] <= cfg_data;
        CFG_PROB3:   prob_r[2] <= cfg_data;
        CFG_PROB4:   prob_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Write port and multiplier operand selection.
  always_comb begin
    we = 1'b0; waddr = addr_r; wdata = '0;
    mul_a = '0; mul_b = '0;
    unique case (state_r)
      S_CLEAR: we = 1'b1;
      S_LD: begin
        we = (item_r.bin_length != '0) && (32'(item_r.bin_length) < DEPTH);
        waddr = LEN_BITS'(item_r.bin_length);
        wdata = (item_r.bin_count > CNT_W'(CMAX)) ? CMAX :
                COUNT_BITS'(item_r.bin_count);
      end
      S_DEC: begin
        we = (rdata_r != '0);
        wdata = rdata_r - COUNT_BITS'(1);
      end
      S_ADD_WR: begin
        we = (rdata_r != CMAX);
        wdata = rdata_r + COUNT_BITS'(1);
      end
      S_MUL, S_CUT: begin
        mul_a = (state_r == S_CUT) ? item_r.rand_cut :
                (second_r ? item_r.rand_second : item_r.rand_first);
        mul_b = (mul_step_r == 2'd0) ? 32'(mul_n_r) : 32'(mul_n_r >> 32);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      addr_r <= '0;
      out_valid_r <= 1'b0;
      largest_r <= '0; long_r <= '0; events_r <= '0;
    end else begin
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          addr_r <= addr_r + LEN_BITS'(1);
          if (addr_r == LAST) state_r <= S_IDLE;
        end
        S_IDLE: if (in_ch.valid && !out_valid_r) begin
          item_r <= in_ch.data;
          res_r <= '{status: ((in_ch.data.action == ACT_LOAD) ? ST_LOADED : ST_READ),
                     default: '0};
          unique case (action_t'(in_ch.data.action))
            ACT_LOAD: begin
              addr_r <= LEN_BITS'(in_ch.data.bin_length);
              state_r <= S_LD;
            end
            ACT_EVENT: begin
              addr_r <= first_elig; scan_r <= first_elig;
              total_r <= '0; state_r <= S_SUM_A;
            end
            default: begin
              addr_r <= LEN_BITS'(in_ch.data.bin_length);
              state_r <= S_RD;
            end
          endcase
        end
        S_RD: state_r <= S_RDW;
        S_RDW: begin
          if (item_r.action == ACT_READ && item_r.bin_length != '0 &&
              32'(item_r.bin_length) < DEPTH)
            res_r.count_out <= CNT_W'(rdata_r);
          state_r <= S_OUT;
        end
        S_LD: begin
          if (item_r.bin_length != '0 && 32'(item_r.bin_length) < DEPTH &&
              item_r.bin_count != '0 && LEN_BITS'(item_r.bin_length) > largest_r)
            largest_r <= LEN_BITS'(item_r.bin_length);
          state_r <= S_OUT;
        end
        // Summing pass: each address is issued in the cycle before its data.
        S_SUM_A: begin
          addr_r <= addr_r + LEN_BITS'(1);
          state_r <= S_SUM_W;
        end
        S_SUM_W: begin
          total_r <= total_r + TOT_W'(rdata_r);
          scan_r <= scan_r + LEN_BITS'(1);
          addr_r <= addr_r + LEN_BITS'(1);
          if (scan_r == LAST) state_r <= S_CHK;
        end
        S_CHK: begin
          if (total_r <= TOT_W'(1)) begin
            res_r.status <= ST_EXHAUSTED;
            state_r <= S_OUT;
          end else begin
            second_r <= 1'b0; mul_n_r <= total_r; mul_step_r <= 2'd0;
            state_r <= S_MUL;
          end
        end
        // Scale: low 32 bits of n first, then the high part.
        S_MUL: begin
          mul_step_r <= mul_step_r + 2'd1;
          state_r <= S_MULW;
        end
        S_MULW: begin
          if (mul_step_r == 2'd1) begin
            acc_r <= TOT_W'(prod_r >> 32);
            state_r <= S_MUL;
          end else begin
            idx_r <= acc_r + TOT_W'(prod_r);
            run_r <= '0;
            addr_r <= first_elig; scan_r <= first_elig;
            state_r <= S_PICK_A;
          end
        end
        S_PICK_A: begin
          addr_r <= addr_r + LEN_BITS'(1);
          state_r <= S_PICK_W;
        end
        S_PICK_W: begin
          if (run_r + TOT_W'(rdata_r) > idx_r || scan_r == LAST) begin
            if (run_r + TOT_W'(rdata_r) > idx_r) addr_r <= scan_r;
            else addr_r <= first_elig;
            state_r <= S_CHOOSE;
          end else begin
            run_r <= run_r + TOT_W'(rdata_r);
            scan_r <= scan_r + LEN_BITS'(1);
            addr_r <= addr_r + LEN_BITS'(1);
          end
        end
        S_CHOOSE: state_r <= S_DEC; // data of chosen bin now arriving
        S_DEC: begin
          if (!second_r) begin
            pick_a_r <= addr_r;
            second_r <= 1'b1; mul_n_r <= total_r - TOT_W'(1);
            mul_step_r <= 2'd0; state_r <= S_MUL;
          end else begin
            pick_b_r <= addr_r;
            mul_step_r <= 2'd0;
            if (item_r.rand_choice < hyd_r)
              mul_n_r <= TOT_W'(pick_a_r) - TOT_W'(1);
            else
              mul_n_r <= TOT_W'(pick_a_r) + TOT_W'(addr_r) - TOT_W'(1);
            state_r <= S_CUT;
          end
        end
        S_CUT: state_r <= S_CUTW;
        S_CUTW: begin
          cut_r <= (LEN_BITS + 1)'(prod_r >> 32) + (LEN_BITS + 1)'(1);
          state_r <= S_DECIDE;
        end
        S_DECIDE: begin
          events_r <= events_r + 32'd1;
          nadd_r <= 2'd0;
          if (item_r.rand_choice < hyd_r) begin
            if (pick_a_r > LEN_BITS'(1)) begin
              res_r.status <= ST_BROKEN;
              res_r.length_a <= LEN_W'(cut_r);
              res_r.length_b <= LEN_W'({1'b0, pick_a_r} - cut_r);
              add_len[0] <= cut_r;
              add_len[1] <= {1'b0, pick_a_r} - cut_r;
              add_len[2] <= {1'b0, pick_b_r};
              adds_r <= 2'd3;
            end else begin
              res_r.status <= ST_MONOMER;
              add_len[0] <= {1'b0, pick_a_r};
              add_len[1] <= {1'b0, pick_b_r};
              adds_r <= 2'd2;
            end
          end else begin
            other_r <= {1'b0, pick_a_r} + {1'b0, pick_b_r} - cut_r;
            if (pick_a_r >= rmin && pick_b_r >= rmin &&
                !(graded_r && mlen >= LEN_BITS'(1) && mlen < LEN_BITS'(GRADED_BELOW) &&
                  {1'b0, item_r.rand_grade} >= prob_r[2'(mlen - LEN_BITS'(1))]) &&
                cut_r < (LEN_BITS + 1)'(DEPTH) &&
                ({1'b0, pick_a_r} + {1'b0, pick_b_r} - cut_r) < (LEN_BITS + 1)'(DEPTH)) begin
              res_r.status <= ST_RECOMB;
              add_len[0] <= cut_r;
              add_len[1] <= {1'b0, pick_a_r} + {1'b0, pick_b_r} - cut_r;
            end else begin
              res_r.status <= ST_REJECTED;
              add_len[0] <= {1'b0, pick_a_r};
              add_len[1] <= {1'b0, pick_b_r};
            end
            adds_r <= 2'd2;
          end
          state_r <= S_ADD_A;
        end
        S_ADD_A: begin
          if (res_r.status == ST_RECOMB && nadd_r == 2'd0) begin
            res_r.length_a <= LEN_W'(cut_r);
            res_r.length_b <= LEN_W'(other_r);
            if (cut_r >= (LEN_BITS + 1)'(LONG_PIECE) ||
                other_r >= (LEN_BITS + 1)'(LONG_PIECE))
              long_r <= long_r + 32'd1;
            if (LEN_BITS'(cut_r) > largest_r && LEN_BITS'(cut_r) >= LEN_BITS'(other_r))
              largest_r <= LEN_BITS'(cut_r);
            else if (LEN_BITS'(other_r) > largest_r)
              largest_r <= LEN_BITS'(other_r);
          end
          if (nadd_r == adds_r) state_r <= S_OUT;
          else begin
            addr_r <= LEN_BITS'(add_len[nadd_r]);
            state_r <= (add_len[nadd_r] == '0) ? S_ADD_A : S_ADD_W;
            nadd_r <= nadd_r + 2'd1;
          end
        end
        S_ADD_W: state_r <= S_ADD_WR;
        S_ADD_WR: state_r <= S_ADD_A;
        S_OUT: begin
          res_r.max_length <= largest_r;
          res_r.long_product_count <= long_r;
          res_r.event_count <= events_r;
          out_valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== sv/orstep_checker.sv =====
// Port-level checker for the oligomer recombination step block.
module orstep_sva (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [2:0] status,
  input logic [31:0] event_count
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status))
    else $error("result beat dropped while stalled");
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> status != 3'd7)
    else $error("undefined status");
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready || !in_valid || $stable(event_count))
    else $error("event counter moved while result waits");
endmodule

bind oligomer_recombination_step_top orstep_sva u_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .status(out_ch.data.status), .event_count(out_ch.data.event_count)
);
